### hdl/emt_pkg.sv
// ----------------------------------------------------------------------------
// emt_pkg - shared types and constants of the extent map table
// Entry layout, operation and status codes, sequencer states, result word.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int unsigned MaxEntriesDefault = 256;
  localparam int unsigned CapWidth          = 9;
  localparam logic [CapWidth-1:0] CapReset  = 9'd256;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_NOHIT  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] length;
    logic [47:0] physical;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_index;
    logic        hit;
    entry_t      entry;
    logic [47:0] freed_start;
    logic [15:0] freed_count;
    logic [8:0]  entries_now;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_FETCH,
    ST_DECIDE,
    ST_SHCK,
    ST_SHWR,
    ST_PUT,
    ST_RESP
  } state_e;

endpackage

### hdl/emt_store.sv
// ----------------------------------------------------------------------------
// emt_store - entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module emt_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned IdxW  = 8
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output emt_pkg::entry_t   rd_data_o,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  emt_pkg::entry_t   wr_data_i
);
  import emt_pkg::*;

  entry_t mem [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/emt_ctrl.sv
// ----------------------------------------------------------------------------
// emt_ctrl - request sequencer
// Binary search, remove decision, and entry shifting over the entry memory.
// ----------------------------------------------------------------------------
module emt_ctrl #(
  parameter int unsigned MaxEntries = 256,
  parameter int unsigned IdxW       = 8,
  parameter int unsigned CntW       = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [emt_pkg::CapWidth-1:0]  cap_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [31:0]                   logical_block_i,
  input  logic [15:0]                   new_length_i,
  input  logic [47:0]                   new_physical_i,
  input  logic [31:0]                   remove_count_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output emt_pkg::rsp_t                 res_o,
  output logic                          rd_en_o,
  output logic [IdxW-1:0]               rd_addr_o,
  input  emt_pkg::entry_t               rd_data_i,
  output logic                          wr_en_o,
  output logic [IdxW-1:0]               wr_addr_o,
  output emt_pkg::entry_t               wr_data_o
);
  import emt_pkg::*;

  state_e      state_q, state_d;
  logic [CntW-1:0] count_q, lo_q, hi_q, idx_q, p_q;
  logic [1:0]  func_q;
  logic [31:0] blk_q, rcount_q;
  entry_t      new_q, e_q, put_q;
  rsp_t        res_q;

  logic [CntW:0]   sum_w;
  logic [CntW-1:0] mid_w;
  logic            accept_w, full_w, search_done_w;
  logic [31:0]     diff_w;
  logic            hit_w, whole_w, end_run_w;
  logic [15:0]     off_w, room_w, fl_w;
  logic [16:0]     run_end_w;
  logic            shift_more_w;
  rsp_t            res_init_w;
  entry_t          trim_w;

  assign sum_w    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w    = sum_w[CntW:1];
  assign accept_w = in_valid_i && !in_stall_o;
  assign full_w   = (32'(count_q) >= 32'(cap_i)) || (32'(count_q) >= 32'(MaxEntries));
  assign search_done_w = !(lo_q < hi_q);

  // remove arithmetic on the fetched floor entry
  assign diff_w    = blk_q - e_q.start;
  assign hit_w     = diff_w < {16'd0, e_q.length};
  assign off_w     = diff_w[15:0];
  assign room_w    = e_q.length - off_w;
  assign fl_w      = (rcount_q < {16'd0, room_w}) ? rcount_q[15:0] : room_w;
  assign whole_w   = (off_w == 16'd0) && (fl_w == e_q.length);
  assign run_end_w = {1'b0, off_w} + {1'b0, fl_w};
  assign end_run_w = run_end_w == {1'b0, e_q.length};

  assign shift_more_w = (func_q == FUNC_INSERT) ? (p_q > idx_q)
                                                : ((32'(p_q) + 32'd1) < 32'(count_q));

  // response word preset at accept
  always_comb begin
    res_init_w        = '0;
    res_init_w.status = (func_i == FUNC_INSERT && full_w) ? STAT_FULL : STAT_NOHIT;
  end

  // entry left behind by a partial remove
  always_comb begin
    trim_w = e_q;
    if (off_w == 16'd0) begin
      // front trim: advance start and physical
      trim_w.start    = e_q.start + {16'd0, fl_w};
      trim_w.physical = e_q.physical + {32'd0, fl_w};
      trim_w.length   = e_q.length - fl_w;
    end else if (end_run_w) begin
      trim_w.length = e_q.length - fl_w;
    end else begin
      trim_w.length = off_w;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          if ((func_i == FUNC_INSERT && full_w) ||
              !(func_i == FUNC_LOOKUP || func_i == FUNC_INSERT || func_i == FUNC_REMOVE)) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (!search_done_w) begin
          state_d = ST_SCMP;
        end else if (func_q == FUNC_INSERT) begin
          state_d = ST_SHCK;
        end else if (lo_q == '0) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_SCMP:   state_d = ST_SRCH;
      ST_FETCH:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (func_q == FUNC_REMOVE && hit_w) begin
          state_d = whole_w ? ST_SHCK : ST_PUT;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHCK: begin
        if (shift_more_w) begin
          state_d = ST_SHWR;
        end else if (func_q == FUNC_INSERT) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHWR:   state_d = ST_SHCK;
      ST_PUT:    state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    res_valid_o = state_q == ST_RESP;
    res_o       = res_q;
    res_o.entries_now = 9'(count_q);
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = p_q[IdxW-1:0];
    wr_data_o = rd_data_i;
    case (state_q)
      ST_SRCH: begin
        rd_en_o   = !search_done_w || (func_q != FUNC_INSERT && lo_q != '0);
        rd_addr_o = !search_done_w ? mid_w[IdxW-1:0] : IdxW'(lo_q - 1'b1);
      end
      ST_SHCK: begin
        rd_en_o   = shift_more_w;
        rd_addr_o = (func_q == FUNC_INSERT) ? IdxW'(p_q - 1'b1) : IdxW'(p_q + 1'b1);
      end
      ST_SHWR: begin
        wr_en_o = 1'b1;
      end
      ST_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q[IdxW-1:0];
        wr_data_o = put_q;
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PUT && func_q == FUNC_INSERT) begin
        count_q <= count_q + 1'b1;
      end else if (state_q == ST_SHCK && !shift_more_w && func_q == FUNC_REMOVE) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          func_q   <= func_i;
          blk_q    <= logical_block_i;
          rcount_q <= remove_count_i;
          new_q    <= '{start: logical_block_i, length: new_length_i,
                        physical: new_physical_i};
          lo_q     <= '0;
          hi_q     <= count_q;
          res_q    <= res_init_w;
        end
      end
      ST_SRCH: begin
        if (search_done_w) begin
          idx_q <= (func_q == FUNC_INSERT) ? lo_q : lo_q - 1'b1;
          p_q   <= count_q;
          put_q <= new_q;
        end
      end
      ST_SCMP: begin
        if (blk_q < rd_data_i.start) begin
          hi_q <= mid_w;
        end else begin
          lo_q <= mid_w + 1'b1;
        end
      end
      ST_FETCH: begin
        e_q <= rd_data_i;
      end
      ST_DECIDE: begin
        p_q <= idx_q;
        if (func_q == FUNC_LOOKUP) begin
          res_q.status      <= STAT_DONE;
          res_q.entry_index <= 8'(idx_q);
          res_q.hit         <= hit_w;
          res_q.entry       <= e_q;
        end else if (hit_w) begin
          res_q.status      <= STAT_DONE;
          res_q.entry_index <= 8'(idx_q);
          res_q.hit         <= 1'b1;
          res_q.entry       <= e_q;
          res_q.freed_start <= e_q.physical + {32'd0, off_w};
          res_q.freed_count <= fl_w;
          put_q             <= trim_w;
        end
      end
      ST_SHWR: begin
        p_q <= (func_q == FUNC_INSERT) ? p_q - 1'b1 : p_q + 1'b1;
      end
      ST_PUT: begin
        if (func_q == FUNC_INSERT) begin
          res_q.status      <= STAT_DONE;
          res_q.entry_index <= 8'(idx_q);
          res_q.entry       <= put_q;
        end
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MaxEntries))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |=> $stable(count_q) || state_q != ST_IDLE)
    else $error("entry count moved while idle");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == ST_SHWR || state_q == ST_PUT))
    else $error("memory write outside shift or put");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCMP) |-> (lo_q < hi_q && hi_q <= count_q))
    else $error("search window out of range");

endmodule

### hdl/extent_map_table.sv
// ----------------------------------------------------------------------------
// extent_map_table - sorted extent leaf with lookup, insert and remove-run
// Keeps one leaf of extents sorted by logical start in a single memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | func, block, length, phys, count
//  out     | output    | out_valid_o / out_stall_i | status, entry, freed run, count
//  cfg     | input     | cfg_valid_i / cfg_ready_o | node capacity (9 bits)
//
//  Flow: one word at a time. Each binary search probe reads the entry
//  memory (registered read) and then compares. Insert and a whole-extent
//  remove then shift the entries one by one, each shift a read and a
//  write of the entry memory.
//  Reset: entry count zero, capacity 256; memory contents stay undefined.
//  Stalls: a finished word sits in the output register; the sequencer holds
//  its last state until that register frees up.
// ----------------------------------------------------------------------------
module extent_map_table #(
  parameter int unsigned MaxEntries = emt_pkg::MaxEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] logical_block_i,
  input  logic [15:0] new_length_i,
  input  logic [47:0] new_physical_i,
  input  logic [31:0] remove_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  entry_index_o,
  output logic        hit_o,
  output logic [31:0] entry_start_o,
  output logic [15:0] entry_length_o,
  output logic [47:0] entry_physical_o,
  output logic [47:0] freed_start_o,
  output logic [15:0] freed_count_o,
  output logic [8:0]  entries_now_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [emt_pkg::CapWidth-1:0] cfg_data_i
);
  import emt_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  logic [CapWidth-1:0] cap_q;
  logic      out_valid_q;
  rsp_t      out_q;
  rsp_t      res_w;
  logic      res_valid_w, res_ready_w;
  logic      rd_en_w, wr_en_w;
  logic [IdxW-1:0] rd_addr_w, wr_addr_w;
  entry_t    rd_data_w, wr_data_w;

  // capacity register; the user must write it only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  emt_ctrl #(
    .MaxEntries (MaxEntries),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_i           (cap_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .logical_block_i (logical_block_i),
    .new_length_i    (new_length_i),
    .new_physical_i  (new_physical_i),
    .remove_count_i  (remove_count_i),
    .res_valid_o     (res_valid_w),
    .res_ready_i     (res_ready_w),
    .res_o           (res_w),
    .rd_en_o         (rd_en_w),
    .rd_addr_o       (rd_addr_w),
    .rd_data_i       (rd_data_w),
    .wr_en_o         (wr_en_w),
    .wr_addr_o       (wr_addr_w),
    .wr_data_o       (wr_data_w)
  );

  emt_store #(
    .Depth (MaxEntries),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en_w),
    .rd_addr_i (rd_addr_w),
    .rd_data_o (rd_data_w),
    .wr_en_i   (wr_en_w),
    .wr_addr_i (wr_addr_w),
    .wr_data_i (wr_data_w)
  );

  // output register: load when empty or draining, drop when taken
  assign res_ready_w = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_w) begin
      out_valid_q <= res_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_w && res_valid_w) begin
      out_q <= res_w;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign entry_index_o    = out_q.entry_index;
  assign hit_o            = out_q.hit;
  assign entry_start_o    = out_q.entry.start;
  assign entry_length_o   = out_q.entry.length;
  assign entry_physical_o = out_q.entry.physical;
  assign freed_start_o    = out_q.freed_start;
  assign freed_count_o    = out_q.freed_count;
  assign entries_now_o    = out_q.entries_now;

endmodule
